// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising edge of clk_i, disabled while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert a property that must also hold during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ===== src/tctl_pkg.sv =====
// Package for the tile cache tag lookup: constants, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tctl_pkg;
  localparam int unsigned CacheEntries = 64;
  localparam int unsigned MaxTileEdge  = 128;
  localparam int unsigned CoordBits    = 20;
  localparam int unsigned LevelBits    = 5;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 20;

  localparam logic [CfgIdxBits-1:0] RegLevelCount   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegImageLines   = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegImageSamples = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegTileEdge     = 2'd3;

  localparam logic [LevelBits-1:0] LevelSkip = 5'h1f;  // -1: no bounds check
endpackage
`default_nettype wire

// ===== src/tctl_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on tctl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tctl_divider import tctl_pkg::*; #(
  parameter int unsigned W = CoordBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W-1:0]    quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [W:0]      trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit into the partial remainder
      if (!trial[W]) begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== src/tctl_tag_store.sv =====
// Tag store: valid bits in flops, tags in a memory scanned one entry a cycle.
// Depends on tctl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tctl_tag_store import tctl_pkg::*; #(
  parameter int unsigned Entries = CacheEntries,
  parameter int unsigned CW      = CoordBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [CW-1:0]              row_i,
  input  wire logic [CW-1:0]              col_i,
  input  wire logic [LevelBits-1:0]       level_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [$clog2(Entries)-1:0]      slot_o
);
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned TagW = 2 * CW + LevelBits;

  typedef enum logic [1:0] {SIdle, SScan, SCheck} state_e;

  state_e             state_q;
  logic [Entries-1:0] valid_q;
  logic [TagW-1:0]    tags [Entries];
  logic [TagW-1:0]    rd_q;
  logic [IdxW-1:0]    addr_q, rd_addr_q, fill_q, slot_q;
  logic               rd_vld_q, done_q, hit_q, last_q;
  logic [TagW-1:0]    key;
  logic               match;

  assign key   = {row_i, col_i, level_i};
  assign match = rd_vld_q && (rd_q == key);

  // registered read, one address per cycle
  always_ff @(posedge clk_i) begin
    rd_q <= tags[addr_q];
    if (state_q == SCheck && !hit_q) tags[fill_q] <= key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= '0;
      addr_q    <= '0;
      rd_addr_q <= '0;
      fill_q    <= '0;
      slot_q    <= '0;
      rd_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      hit_q     <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            addr_q   <= '0;
            rd_vld_q <= 1'b0;
            hit_q    <= 1'b0;
            last_q   <= 1'b0;
            state_q  <= SScan;
          end
        end
        SScan: begin
          // read data for rd_addr_q arrives this cycle
          rd_vld_q  <= valid_q[addr_q];
          rd_addr_q <= addr_q;
          if (match && !hit_q) begin
            hit_q  <= 1'b1;
            slot_q <= rd_addr_q;
          end
          if (last_q) begin
            state_q <= SCheck;
          end
          if (addr_q == IdxW'(Entries - 1)) last_q <= 1'b1;
          else addr_q <= addr_q + 1'b1;
        end
        SCheck: begin
          if (match && !hit_q) begin
            hit_q  <= 1'b1;
            slot_q <= rd_addr_q;
          end else if (!hit_q) begin
            valid_q[fill_q] <= 1'b1;
            slot_q <= fill_q;
            fill_q <= (fill_q == IdxW'(Entries - 1)) ? '0 : fill_q + 1'b1;
          end
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign slot_o = slot_q;
endmodule
`default_nettype wire

// ===== src/tile_cache_tag_lookup_core.sv =====
// Top level of the tile cache tag lookup: sequencer, registers, stream ports.
// Depends on tctl_pkg, tctl_divider and tctl_tag_store.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. A checked request runs two bound divisions by
// level+1, then every passing request runs two divisions by the saturated
// tile edge; each division holds the shared bit-serial divider. The tag
// scan then reads the tag memory one entry a cycle. A request rejected on
// its level goes straight to the output; one rejected on its coordinates
// after the bound check skips the tile divisions and the tag scan.
// The result waits in an output register and s_axis_tready stays low until
// it is taken.
module tile_cache_tag_lookup_core import tctl_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CacheEntries,
  parameter int unsigned MAX_TILE_EDGE = MaxTileEdge,
  parameter int unsigned COORD_BITS    = CoordBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [CfgDataBits-1:0]    cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // res_level[4:0], pixel_line, pixel_sample, zero fill
  input  wire logic [((LevelBits+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // out_of_range, hit, slot, tile_row, tile_col, row_in_tile, col_in_tile
  output logic [((2+$clog2(CACHE_ENTRIES)+2*COORD_BITS
                  +2*$clog2(MAX_TILE_EDGE)+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned IdxW  = $clog2(CACHE_ENTRIES);
  localparam int unsigned OffW  = $clog2(MAX_TILE_EDGE);
  localparam int unsigned EdgeW = OffW + 1;
  localparam int unsigned OutW  = 2 + IdxW + 2 * CW + 2 * OffW;
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8;

  typedef enum logic [3:0] {
    SIdle, SChkA, SWaitA, SChkB, SWaitB, SDivA, SWaitC, SDivB, SWaitD, SScan, SOut
  } state_e;

  state_e               state_q;
  logic [4:0]           lvl_cnt_q;
  logic [CW-1:0]        img_lines_q, img_samples_q;
  logic [7:0]           tile_edge_q;
  logic [LevelBits-1:0] lvl_q;
  logic [CW-1:0]        line_q, sample_q, trow_q, tcol_q;
  logic [OffW-1:0]      roff_q, coff_q;
  logic                 bad_q, ovld_q, hit_q;
  logic [IdxW-1:0]      slot_q;
  logic [CW-1:0]        div_a, div_b, quot, rem;
  logic                 div_start, div_busy, div_done;
  logic                 tag_start, tag_done, tag_hit;
  logic [IdxW-1:0]      tag_slot;
  logic [EdgeW-1:0]     edge_sat;
  logic [OutW-1:0]      res;

  // saturate the edge into 1..MAX_TILE_EDGE
  always_comb begin
    if (tile_edge_q == '0) edge_sat = EdgeW'(1);
    else if (32'(tile_edge_q) > MAX_TILE_EDGE) edge_sat = EdgeW'(MAX_TILE_EDGE);
    else edge_sat = EdgeW'(tile_edge_q);
  end

  always_comb begin
    div_start = ((state_q == SChkA) || (state_q == SChkB)
              || (state_q == SDivA) || (state_q == SDivB)) && !div_busy;
    case (state_q)
      SChkA:   begin div_a = img_lines_q;   div_b = CW'(lvl_q) + 1'b1; end
      SChkB:   begin div_a = img_samples_q; div_b = CW'(lvl_q) + 1'b1; end
      SDivA:   begin div_a = line_q;        div_b = CW'(edge_sat);     end
      default: begin div_a = sample_q;      div_b = CW'(edge_sat);     end
    endcase
  end

  tctl_divider #(.W(CW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .busy_o(div_busy), .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  tctl_tag_store #(.Entries(CACHE_ENTRIES), .CW(CW)) u_tags (
    .clk_i, .rst_ni,
    .start_i(tag_start), .row_i(trow_q), .col_i(tcol_q), .level_i(lvl_q),
    .done_o(tag_done), .hit_o(tag_hit), .slot_o(tag_slot)
  );
  assign tag_start = (state_q == SWaitD) && div_done;

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ovld_q;
  assign res = bad_q ? OutW'(1)
             : {coff_q, roff_q, tcol_q, trow_q, slot_q, hit_q, 1'b0};
  assign m_axis_tdata = OutTW'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      lvl_cnt_q     <= 5'd1;
      img_lines_q   <= '0;
      img_samples_q <= '0;
      tile_edge_q   <= 8'd128;
      ovld_q        <= 1'b0;
      bad_q         <= 1'b0;
      trow_q        <= '0;
      tcol_q        <= '0;
      roff_q        <= '0;
      coff_q        <= '0;
      hit_q         <= 1'b0;
      slot_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLevelCount:   lvl_cnt_q     <= cfg_data_i[4:0];
          RegImageLines:   img_lines_q   <= CW'(cfg_data_i);
          RegImageSamples: img_samples_q <= CW'(cfg_data_i);
          RegTileEdge:     tile_edge_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            bad_q <= 1'b0;
            if (s_axis_tdata[LevelBits-1:0] == LevelSkip) state_q <= SDivA;
            else if (s_axis_tdata[LevelBits-1] ||
                     s_axis_tdata[LevelBits-1:0] >= lvl_cnt_q) begin
              bad_q   <= 1'b1;
              state_q <= SOut;
              ovld_q  <= 1'b1;
            end else state_q <= SChkA;
          end
        end
        SChkA:  state_q <= SWaitA;
        SWaitA: if (div_done) begin
          if (line_q > quot) bad_q <= 1'b1;
          state_q <= SChkB;
        end
        SChkB:  state_q <= SWaitB;
        SWaitB: if (div_done) begin
          if (bad_q || sample_q > quot) begin
            bad_q   <= 1'b1;
            state_q <= SOut;
            ovld_q  <= 1'b1;
          end else state_q <= SDivA;
        end
        SDivA:  state_q <= SWaitC;
        SWaitC: if (div_done) begin
          trow_q  <= quot;
          roff_q  <= rem[OffW-1:0];
          state_q <= SDivB;
        end
        SDivB:  state_q <= SWaitD;
        SWaitD: if (div_done) begin
          tcol_q  <= quot;
          coff_q  <= rem[OffW-1:0];
          state_q <= SScan;
        end
        SScan: if (tag_done) begin
          hit_q   <= tag_hit;
          slot_q  <= tag_slot;
          ovld_q  <= 1'b1;
          state_q <= SOut;
        end
        SOut: if (m_axis_tready) begin
          ovld_q  <= 1'b0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && s_axis_tvalid) begin
      lvl_q    <= s_axis_tdata[LevelBits-1:0];
      line_q   <= s_axis_tdata[LevelBits +: CW];
      sample_q <= s_axis_tdata[LevelBits+CW +: CW];
    end
  end
endmodule
`default_nettype wire

// ===== src/tctl_checker.sv =====
// Port-level checker for the tile cache tag lookup, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tctl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);
  // one request in flight: no new transfer while a result waits
  `ASSERT_CLK(a_no_in_while_out, m_axis_tvalid |-> !s_axis_tready, "input ready with result")
  // a result waits until taken
  `ASSERT_CLK(a_out_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  // ready drops after an accepted transfer
  `ASSERT_CLK(a_in_drops_ready, s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
              "ready stayed high after transfer")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid in reset")
endmodule

bind tile_cache_tag_lookup_core tctl_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for tile_cache_tag_lookup_core: directed and random pixel requests,
// self-checking against an in-bench tag-store predictor. Depends on tctl_pkg.
`timescale 1ns / 1ps
module tb_top;
  import tctl_pkg::*;

  localparam int InW      = 48;
  localparam int OutW     = 64;
  localparam int CycLimit = 2000000;

  typedef struct packed {
    logic        oor;
    logic        hit;
    logic [5:0]  slot;
    logic [19:0] trow;
    logic [19:0] tcol;
    logic [6:0]  rit;
    logic [6:0]  cit;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;  // res_level[4:0], pixel_line, pixel_sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_of_range, hit, slot, tile_row, tile_col, row_in_tile, col_in_tile
  logic [OutW-1:0] m_axis_tdata;

  tile_cache_tag_lookup_core dut (.*);

  // predictor state
  logic [4:0]  lvl_count_q = 5'd1;
  logic [19:0] img_lines_q = '0;
  logic [19:0] img_samples_q = '0;
  logic [7:0]  tile_edge_q = 8'd128;
  logic        tag_valid[CacheEntries];
  logic [19:0] tag_row[CacheEntries];
  logic [19:0] tag_col[CacheEntries];
  logic [4:0]  tag_lvl[CacheEntries];
  logic [5:0]  fill_ptr = '0;

  lookup_t pending_q[$];
  int n_mismatch = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_oor = 0;
  int n_sent = 0;
  int cycles = 0;
  bit no_idle = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (tag_valid[i]) tag_valid[i] = 1'b0;
  end

  function automatic lookup_t predict_lookup(logic [4:0] lvl, logic [19:0] line,
                                             logic [19:0] sample);
    lookup_t r;
    int lv;
    int tedge;
    int slot;
    bit found;
    r = '0;
    lv = $signed(lvl);
    found = 0;
    slot = 0;
    if (lvl != LevelSkip) begin
      if (lv < 0 || lv >= int'(lvl_count_q) ||
          line > img_lines_q / (lv + 1) || sample > img_samples_q / (lv + 1)) begin
        r.oor = 1'b1;
        return r;
      end
    end
    tedge = (tile_edge_q == 0) ? 1 : (tile_edge_q > MaxTileEdge) ? MaxTileEdge
                                                                  : tile_edge_q;
    r.trow = 20'(line / tedge);
    r.tcol = 20'(sample / tedge);
    r.rit  = 7'(line % tedge);
    r.cit  = 7'(sample % tedge);
    for (int i = 0; i < CacheEntries; i++) begin
      if (!found && tag_valid[i] && tag_row[i] == r.trow && tag_col[i] == r.tcol &&
          tag_lvl[i] == lvl) begin
        found = 1;
        slot = i;
      end
    end
    if (!found) begin
      slot = fill_ptr;
      tag_valid[slot] = 1'b1;
      tag_row[slot] = r.trow;
      tag_col[slot] = r.tcol;
      tag_lvl[slot] = lvl;
      fill_ptr = 6'(fill_ptr + 1);
    end
    r.hit = found;
    r.slot = 6'(slot);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // result sink stalls
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready = (pick_gap() == 0);
    end
  end

  always @(posedge clk_i) begin
    lookup_t e;
    lookup_t a;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.oor  = m_axis_tdata[0];
      a.hit  = m_axis_tdata[1];
      a.slot = m_axis_tdata[7:2];
      a.trow = m_axis_tdata[27:8];
      a.tcol = m_axis_tdata[47:28];
      a.rit  = m_axis_tdata[54:48];
      a.cit  = m_axis_tdata[61:55];
      n_results++;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: unexpected result %h", m_axis_tdata);
      end else begin
        e = pending_q.pop_front();
        n_hits += e.hit;
        n_oor += e.oor;
        if (a != e) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d exp oor=%0d hit=%0d slot=%0d row=%0d col=%0d rit=%0d cit=%0d / got oor=%0d hit=%0d slot=%0d row=%0d col=%0d rit=%0d cit=%0d",
                     n_results, e.oor, e.hit, e.slot, e.trow, e.tcol, e.rit, e.cit,
                     a.oor, a.hit, a.slot, a.trow, a.tcol, a.rit, a.cit);
        end
      end
    end
    if (cycles > CycLimit) begin
      $display("ERROR: timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_req(logic [4:0] lvl, logic [19:0] line, logic [19:0] sample);
    repeat (pick_gap()) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = '0;
    s_axis_tdata[44:0] = {sample, line, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict_lookup(lvl, line, sample));
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegLevelCount:   lvl_count_q = val[4:0];
      RegImageLines:   img_lines_q = val;
      RegImageSamples: img_samples_q = val;
      RegTileEdge:     tile_edge_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [4:0] lc, logic [19:0] lines, logic [19:0] samples,
                            logic [7:0] te);
    wait_idle();
    write_reg(RegLevelCount, 20'(lc));
    write_reg(RegImageLines, lines);
    write_reg(RegImageSamples, samples);
    write_reg(RegTileEdge, 20'(te));
  endtask

  // reset state: count 1, empty image, so only level -1 and (0,0,0) pass
  task automatic test_reset_defaults();
    send_req(5'd0, 20'd0, 20'd0);
    send_req(5'd0, 20'd1, 20'd0);
    send_req(LevelSkip, 20'd5, 20'd7);
    send_req(LevelSkip, 20'd100, 20'd3);      // same tile: hit
    send_req(5'd1, 20'd0, 20'd0);             // level beyond count
  endtask

  task automatic test_bounds();
    set_config(5'd16, 20'hFFFFF, 20'hFFFFF, 8'd128);
    send_req(5'd0, 20'hFFFFF, 20'hFFFFF);
    send_req(5'd15, 20'hFFFFF / 16, 20'hFFFFF / 16);        // inclusive upper test
    send_req(5'd15, 20'hFFFFF / 16 + 1, 20'd0);
    send_req(5'd15, 20'd0, 20'hFFFFF / 16 + 1);
    send_req(5'h1E, 20'd0, 20'd0);                         // -2
    send_req(5'h10, 20'd0, 20'd0);                         // -16
    send_req(LevelSkip, 20'hFFFFF, 20'hFFFFF);
    send_req(5'd0, 20'hFFFFF, 20'hFFFFF);                  // hit
    set_config(5'd0, 20'd1000, 20'd1000, 8'd64);           // count 0 rejects all checked
    send_req(5'd0, 20'd1, 20'd1);
    send_req(LevelSkip, 20'd1, 20'd1);
    set_config(5'd31, 20'd1000, 20'd1000, 8'd0);           // edge 0 saturates to 1
    send_req(5'd15, 20'd62, 20'd61);
    send_req(5'd3, 20'd250, 20'd251);
  endtask

  task automatic test_edges();
    set_config(5'd4, 20'd5000, 20'd5000, 8'd255);          // saturates to 128
    send_req(5'd0, 20'd4999, 20'd127);
    send_req(5'd0, 20'd4990, 20'd0);
    set_config(5'd4, 20'd5000, 20'd5000, 8'd1);
    send_req(5'd1, 20'd2500, 20'd2500);
    set_config(5'd4, 20'd5000, 20'd5000, 8'd129);
    send_req(5'd2, 20'd1666, 20'd129);
  endtask

  // more than CacheEntries distinct tiles, then revisits: wraps the fill pointer
  task automatic test_eviction();
    set_config(5'd2, 20'd100000, 20'd100000, 8'd8);
    for (int i = 0; i < 80; i++) send_req(5'd0, 20'(i * 8), 20'd3);
    for (int i = 0; i < 20; i++) send_req(5'd0, 20'($urandom_range(79) * 8), 20'd5);
  endtask

  task automatic test_random();
    logic [4:0] lc;
    logic [19:0] lines, samples;
    logic [7:0] te;
    int lv, p, span;
    logic [19:0] ln, sm;
    for (int ph = 0; ph < 8; ph++) begin
      lc = 5'($urandom_range(16, 1));
      lines = ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom_range(20000));
      samples = ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom_range(20000));
      p = $urandom_range(9);
      te = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd128
                                                         : 8'($urandom_range(64, 1));
      set_config(lc, lines, samples, te);
      no_idle = (ph % 3 == 2);
      for (int k = 0; k < 50; k++) begin
        p = $urandom_range(99);
        if (p < 25) begin
          send_req(5'($urandom()), 20'($urandom()), 20'($urandom()));
        end else begin
          lv = $urandom_range(lc) - 1;
          span = (te == 0 ? 1 : te) * 12;
          ln = 20'($urandom_range((lv < 0) ? span : (lines / (lv + 1) < span ?
                                  lines / (lv + 1) : span)));
          sm = 20'($urandom_range((lv < 0) ? span : (samples / (lv + 1) < span ?
                                  samples / (lv + 1) : span)));
          if (p > 95 && lv >= 0) ln = 20'(lines / (lv + 1) + 1);  // just past bound
          send_req(lv[4:0], ln, sm);
        end
      end
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_bounds();
    test_edges();
    test_eviction();
    test_random();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results (%0d hits, %0d out of range)",
             n_sent, n_results, n_hits, n_oor);
    $display("Covered bound checks, edge saturation, tag eviction and random register settings");
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
